// ===== rtl/klp_pkg.sv =====
// Package of shared types and constants for the keyframe linear player.
`timescale 1ns / 1ps
`default_nettype none
package klp_pkg;
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_TOGGLE = 3'd1;
  localparam logic [2:0] ACT_SAVE   = 3'd2;
  localparam logic [2:0] ACT_JOG    = 3'd3;
  localparam logic [2:0] ACT_WRITE  = 3'd4;
  localparam logic [2:0] ACT_COUNT  = 3'd5;
  localparam logic [15:0] STEPS_RESET = 16'd600;
  typedef logic signed [31:0] fix_t;
endpackage
`default_nettype wire

// ===== rtl/klp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module klp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/keyframe_linear_player_unit.sv =====
// Top level of the keyframe linear player: pose state, key table and serial divider.
// Most actions go from the execute state straight to the result state; set count first reads
// table slot 0, and a toggle that starts playback or a tick that changes segment reads two keys,
// then runs a 33-bit restoring division for each of the three axes in turn.
// One item at a time: idle, where new inputs are taken, follows the result transfer.
// Reset (rst, synchronous, active high) clears pose, increments, counters and flags, sets
// steps_per_segment to 600 and leaves the key table undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_linear_player_unit #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic signed [1:0] jog_dx,
  input  wire logic signed [1:0] jog_dy,
  input  wire logic signed [1:0] jog_turn,
  input  wire logic [5:0]  entry_index,
  input  wire logic signed [31:0] entry_x,
  input  wire logic signed [31:0] entry_y,
  input  wire logic signed [31:0] entry_rot,
  input  wire logic [6:0]  entry_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] pose_rot,
  output logic             playing,
  output logic [5:0]       segment,
  output logic             finished,
  output logic             table_full
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_KEYS);
  localparam int SW = (AW > 6) ? AW : 6;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;  // read address of the first key presented
  localparam logic [3:0] S_RDA2  = 4'd3;  // first key data valid
  localparam logic [3:0] S_RDB2  = 4'd4;  // second key data valid
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_K0    = 4'd8;
  localparam logic [3:0] S_K0W   = 4'd9;

  logic [3:0] state;
  logic [15:0] steps;
  logic [2:0] act;
  logic signed [1:0] jdx, jdy, jtr;
  logic [5:0] eidx;
  logic [95:0] edata;
  logic [6:0] ecount;

  klp_pkg::fix_t cur_x, cur_y, cur_rot, inc_x, inc_y, inc_rot;
  logic [CW-1:0] key_count;
  logic [15:0] step_count;
  logic [SW-1:0] seg_index;
  logic run_flag, fin, full;

  // Table port.
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [95:0] ram_wdata, ram_rdata;
  klp_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Divider: one axis at a time, one quotient bit per cycle on a 33-bit magnitude.
  logic [95:0] key_a;
  logic [1:0] axis;
  logic [32:0] dividend;   // shifts out into quotient
  logic [16:0] rem;
  logic [5:0] bit_cnt;
  logic neg;
  logic [15:0] divisor;
  logic [17:0] trial;
  logic signed [32:0] diff;

  function automatic klp_pkg::fix_t sat_add(input klp_pkg::fix_t a, input klp_pkg::fix_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    else if (s < -33'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

  function automatic klp_pkg::fix_t jog_amt(input logic signed [1:0] j, input logic deg);
    logic signed [39:0] v;
    v = 40'(j) <<< FRAC_BITS;
    if (deg) v = v * 40'sd45;
    return v[31:0];
  endfunction

  assign divisor = (steps == 16'd0) ? 16'd1 : steps;
  assign trial = {rem, dividend[32]} - {2'b00, divisor};
  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE) && !cfg_valid;
  // The first key is addressed in S_RDA; from then on the address stays on the second key.
  assign ram_raddr = (state == S_K0) ? AW'(0) :
                     ((state == S_RDA) ? AW'(seg_index) : AW'(seg_index) + AW'(1));

  // Pose outputs come straight from the state registers during the result state.
  assign pose_x = cur_x;
  assign pose_y = cur_y;
  assign pose_rot = cur_rot;
  assign playing = run_flag;
  assign segment = 6'(seg_index);
  assign finished = fin;
  assign table_full = full;
  assign out_valid = (state == S_OUT);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = AW'(eidx);
    ram_wdata = edata;
    if (state == S_EXEC) begin
      if (act == klp_pkg::ACT_SAVE && key_count < MAXC) begin
        ram_we = 1'b1;
        ram_waddr = AW'(key_count);
        ram_wdata = {cur_x, cur_y, cur_rot};
      end else if (act == klp_pkg::ACT_WRITE && 32'(eidx) < MAX_KEYS) begin
        ram_we = 1'b1;
      end
    end
  end

  always_comb begin
    case (axis)
      2'd0:    diff = 33'(klp_pkg::fix_t'(ram_rdata[95:64])) - 33'(klp_pkg::fix_t'(key_a[95:64]));
      2'd1:    diff = 33'(klp_pkg::fix_t'(ram_rdata[63:32])) - 33'(klp_pkg::fix_t'(key_a[63:32]));
      default: diff = 33'(klp_pkg::fix_t'(ram_rdata[31:0])) - 33'(klp_pkg::fix_t'(key_a[31:0]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= klp_pkg::STEPS_RESET;
      cur_x <= '0; cur_y <= '0; cur_rot <= '0;
      inc_x <= '0; inc_y <= '0; inc_rot <= '0;
      key_count <= '0;
      step_count <= '0;
      seg_index <= '0;
      run_flag <= 1'b0;
      fin <= 1'b0;
      full <= 1'b0;
      axis <= '0;
      bit_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            steps <= cfg_data;
          end else if (in_valid) begin
            act <= action; jdx <= jog_dx; jdy <= jog_dy; jtr <= jog_turn;
            eidx <= entry_index; edata <= {entry_x, entry_y, entry_rot};
            ecount <= entry_count;
            fin <= 1'b0;
            full <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (act)
            klp_pkg::ACT_TICK: begin
              if (run_flag) begin
                if (step_count >= steps) begin
                  // The segment index moves on first, so the end test uses it plus one.
                  if (32'(seg_index) + 3 > 32'(key_count)) begin
                    seg_index <= '0;
                    run_flag <= 1'b0;
                    fin <= 1'b1;
                  end else begin
                    seg_index <= seg_index + SW'(1);
                    step_count <= '0;
                    state <= S_RDA;
                  end
                end else begin
                  cur_x <= sat_add(cur_x, inc_x);
                  cur_y <= sat_add(cur_y, inc_y);
                  cur_rot <= sat_add(cur_rot, inc_rot);
                  step_count <= step_count + 16'd1;
                end
              end
            end
            klp_pkg::ACT_TOGGLE: begin
              if (!run_flag && key_count > CW'(1)) begin
                seg_index <= '0;
                step_count <= '0;
                run_flag <= 1'b1;
                state <= S_RDA;
              end else begin
                run_flag <= 1'b0;
              end
            end
            klp_pkg::ACT_SAVE: begin
              if (key_count < MAXC) key_count <= key_count + CW'(1);
              else full <= 1'b1;
            end
            klp_pkg::ACT_JOG: begin
              cur_x <= sat_add(cur_x, jog_amt(jdx, 1'b0));
              cur_y <= sat_add(cur_y, jog_amt(jdy, 1'b0));
              cur_rot <= sat_add(cur_rot, jog_amt(jtr, 1'b1));
            end
            klp_pkg::ACT_COUNT: begin
              key_count <= (32'(ecount) > MAX_KEYS) ? MAXC : CW'(ecount);
              state <= S_K0;
            end
            default: ;
          endcase
        end
        S_K0: state <= S_K0W;
        S_K0W: begin
          cur_x <= ram_rdata[95:64]; cur_y <= ram_rdata[63:32]; cur_rot <= ram_rdata[31:0];
          state <= S_OUT;
        end
        S_RDA: begin
          // The first key's address is presented in this cycle.
          if (32'(seg_index) + 1 >= MAX_KEYS) begin
            inc_x <= '0; inc_y <= '0; inc_rot <= '0;
            state <= S_OUT;
          end else begin
            state <= S_RDA2;
          end
        end
        S_RDA2: begin
          key_a <= ram_rdata;
          if (act == klp_pkg::ACT_TOGGLE) begin
            cur_x <= ram_rdata[95:64]; cur_y <= ram_rdata[63:32];
            cur_rot <= ram_rdata[31:0];
          end
          state <= S_RDB2;
        end
        S_RDB2: begin
          // Second key data now valid; hold it by keeping the read address on it.
          axis <= 2'd0;
          state <= S_DIVW;
        end
        S_DIVW: begin
          neg <= diff[32];
          dividend <= diff[32] ? 33'(-diff) : 33'(diff);
          rem <= '0;
          bit_cnt <= 6'd33;
          state <= S_DIV;
        end
        S_DIV: begin
          if (bit_cnt != 6'd0) begin
            if (!trial[17]) begin
              rem <= trial[16:0];
              dividend <= {dividend[31:0], 1'b1};
            end else begin
              rem <= {rem[15:0], dividend[32]};
              dividend <= {dividend[31:0], 1'b0};
            end
            bit_cnt <= bit_cnt - 6'd1;
          end else begin
            // Quotient magnitude below 2^32; negate and saturate at both ends.
            logic signed [33:0] q;
            q = neg ? -34'(dividend) : 34'(dividend);
            if (q > 34'sd2147483647) q = 34'sd2147483647;
            else if (q < -34'sd2147483648) q = -34'sd2147483648;
            case (axis)
              2'd0: inc_x <= q[31:0];
              2'd1: inc_y <= q[31:0];
              default: inc_rot <= q[31:0];
            endcase
            if (axis == 2'd2) begin
              state <= S_OUT;
            end else begin
              axis <= axis + 2'd1;
              state <= S_DIVW;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only offered from the result state, and inputs are taken only in idle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(playing))
    else $error("result changed while stalled");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    key_count <= MAXC) else $error("key count beyond capacity");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(finished && table_full)) else $error("both flags set");
endmodule
`default_nettype wire

// ===== tb/tb_keyframe_linear_player_unit.sv =====
// Self-checking testbench for the keyframe linear player with a scoreboard class.
`timescale 1ns / 1ps
module tb_keyframe_linear_player_unit;

  localparam int  NUM_KEYS    = 64;
  localparam int  UNIT        = 65536;
  // A segment change runs three serial divisions, so idle the block well past that.
  localparam int  SETTLE      = 200;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // One result as the block reports it after each transfer on the input side.
  typedef struct packed {
    klp_pkg::fix_t x;
    klp_pkg::fix_t y;
    klp_pkg::fix_t rot;
    logic        play;
    logic [5:0]  seg;
    logic        fin;
    logic        full;
  } pose_result_t;

  // The scoreboard keeps its own copy of the player state and predicts every result.
  class klp_scoreboard;
    klp_pkg::fix_t tab_x[NUM_KEYS];
    klp_pkg::fix_t tab_y[NUM_KEYS];
    klp_pkg::fix_t tab_rot[NUM_KEYS];
    bit           filled[NUM_KEYS];
    int unsigned  key_count;
    klp_pkg::fix_t cur_x, cur_y, cur_rot;
    klp_pkg::fix_t inc_x, inc_y, inc_rot;
    int unsigned  step_cnt;
    int unsigned  seg_idx;
    bit           running;
    int unsigned  steps;
    pose_result_t pending_poses[$];
    int           errors;
    int           matched;
    int           finishes;
    int           refusals;

    function new();
      foreach (filled[i]) filled[i] = 0;
      key_count = 0;
      cur_x = 0; cur_y = 0; cur_rot = 0;
      inc_x = 0; inc_y = 0; inc_rot = 0;
      step_cnt = 0; seg_idx = 0; running = 0;
      steps = klp_pkg::STEPS_RESET;
      errors = 0; matched = 0; finishes = 0; refusals = 0;
    endfunction

    function klp_pkg::fix_t sat(longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
      return klp_pkg::fix_t'(v);
    endfunction

    // Per-tick increment for one axis: difference over the step count, rounded to zero.
    function klp_pkg::fix_t axis_inc(klp_pkg::fix_t to_val, klp_pkg::fix_t from_val);
      longint d;
      d = (steps == 0) ? 1 : steps;
      return sat((longint'(to_val) - longint'(from_val)) / d);
    endfunction

    function void load_incs();
      int unsigned b;
      b = seg_idx + 1;
      if (b >= NUM_KEYS) begin
        inc_x = 0; inc_y = 0; inc_rot = 0;
      end else begin
        inc_x   = axis_inc(tab_x[b], tab_x[seg_idx]);
        inc_y   = axis_inc(tab_y[b], tab_y[seg_idx]);
        inc_rot = axis_inc(tab_rot[b], tab_rot[seg_idx]);
      end
    endfunction

    function void note_item(logic [2:0] act, logic signed [1:0] dx, logic signed [1:0] dy,
                            logic signed [1:0] turn, logic [5:0] idx, klp_pkg::fix_t ex,
                            klp_pkg::fix_t ey, klp_pkg::fix_t er, logic [6:0] cnt);
      pose_result_t r;
      bit fin;
      bit full;
      fin = 0;
      full = 0;
      case (act)
        klp_pkg::ACT_TICK: begin
          if (running) begin
            if (step_cnt >= steps) begin
              seg_idx++;
              if (seg_idx + 2 > key_count) begin
                seg_idx = 0;
                running = 0;
                fin = 1;
              end else begin
                step_cnt = 0;
                load_incs();
              end
            end else begin
              cur_x   = sat(longint'(cur_x) + longint'(inc_x));
              cur_y   = sat(longint'(cur_y) + longint'(inc_y));
              cur_rot = sat(longint'(cur_rot) + longint'(inc_rot));
              step_cnt++;
            end
          end
        end
        klp_pkg::ACT_TOGGLE: begin
          if (!running && key_count > 1) begin
            cur_x = tab_x[0]; cur_y = tab_y[0]; cur_rot = tab_rot[0];
            seg_idx = 0;
            step_cnt = 0;
            load_incs();
            running = 1;
          end else begin
            running = 0;
          end
        end
        klp_pkg::ACT_SAVE: begin
          if (key_count < NUM_KEYS) begin
            tab_x[key_count] = cur_x;
            tab_y[key_count] = cur_y;
            tab_rot[key_count] = cur_rot;
            filled[key_count] = 1;
            key_count++;
          end else begin
            full = 1;
          end
        end
        klp_pkg::ACT_JOG: begin
          cur_x   = sat(longint'(cur_x) + longint'(dx) * UNIT);
          cur_y   = sat(longint'(cur_y) + longint'(dy) * UNIT);
          cur_rot = sat(longint'(cur_rot) + longint'(turn) * 45 * UNIT);
        end
        klp_pkg::ACT_WRITE: begin
          tab_x[idx] = ex;
          tab_y[idx] = ey;
          tab_rot[idx] = er;
          filled[idx] = 1;
        end
        klp_pkg::ACT_COUNT: begin
          key_count = (cnt > NUM_KEYS) ? NUM_KEYS : cnt;
          cur_x = tab_x[0]; cur_y = tab_y[0]; cur_rot = tab_rot[0];
        end
        default: ;
      endcase
      if (fin) finishes++;
      if (full) refusals++;
      r.x = cur_x; r.y = cur_y; r.rot = cur_rot;
      r.play = running;
      r.seg = seg_idx[5:0];
      r.fin = fin;
      r.full = full;
      pending_poses.push_back(r);
    endfunction

    function void check_result(pose_result_t got);
      pose_result_t want;
      if (pending_poses.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      want = pending_poses.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: pose_x expected %h actual %h", $time, want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: pose_y expected %h actual %h", $time, want.y, got.y); errors++;
      end
      if (got.rot !== want.rot) begin
        $display("%0t: pose_rot expected %h actual %h", $time, want.rot, got.rot); errors++;
      end
      if (got.play !== want.play) begin
        $display("%0t: playing expected %b actual %b", $time, want.play, got.play); errors++;
      end
      if (got.seg !== want.seg) begin
        $display("%0t: segment expected %0d actual %0d", $time, want.seg, got.seg); errors++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: finished expected %b actual %b", $time, want.fin, got.fin); errors++;
      end
      if (got.full !== want.full) begin
        $display("%0t: table_full expected %b actual %b", $time, want.full, got.full);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  action = klp_pkg::ACT_TICK;
  logic signed [1:0] jog_dx = '0, jog_dy = '0, jog_turn = '0;
  logic [5:0]  entry_index = '0;
  klp_pkg::fix_t entry_x = '0, entry_y = '0, entry_rot = '0;
  logic [6:0]  entry_count = '0;
  logic        out_valid;
  logic        out_ready = 0;
  klp_pkg::fix_t pose_x, pose_y, pose_rot;
  logic        playing;
  logic [5:0]  segment;
  logic        finished;
  logic        table_full;

  klp_scoreboard sb;
  longint      cycles = 0;
  // When set, neither side inserts gaps, so the block runs back to back.
  bit          no_gaps = 0;

  keyframe_linear_player_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .jog_dx(jog_dx), .jog_dy(jog_dy), .jog_turn(jog_turn),
    .entry_index(entry_index), .entry_x(entry_x), .entry_y(entry_y),
    .entry_rot(entry_rot), .entry_count(entry_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .pose_x(pose_x), .pose_y(pose_y), .pose_rot(pose_rot),
    .playing(playing), .segment(segment), .finished(finished), .table_full(table_full)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Results are sampled at the edge where the transfer takes place.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{pose_x, pose_y, pose_rot, playing, segment, finished, table_full});
  end

  // Unless no_gaps is set, the receiving side stalls for a random number of cycles before each result.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Drives one item; the gap before it is drawn here, and valid holds until the transfer.
  task automatic send_item(logic [2:0] act, logic signed [1:0] dx, logic signed [1:0] dy,
                           logic signed [1:0] turn, logic [5:0] idx, klp_pkg::fix_t ex,
                           klp_pkg::fix_t ey, klp_pkg::fix_t er, logic [6:0] cnt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    action <= act; jog_dx <= dx; jog_dy <= dy; jog_turn <= turn;
    entry_index <= idx; entry_x <= ex; entry_y <= ey; entry_rot <= er;
    entry_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(act, dx, dy, turn, idx, ex, ey, er, cnt);
  endtask

  // Writes steps_per_segment once the block has drained and gone quiet.
  task automatic write_steps(logic [15:0] value);
    if (in_valid) in_valid <= 0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.steps = value;
  endtask

  function automatic klp_pkg::fix_t pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return klp_pkg::fix_t'($urandom);
      default: return klp_pkg::fix_t'($signed($urandom_range(0, 2000)) - 1000) * UNIT
                      + klp_pkg::fix_t'($urandom_range(0, UNIT - 1));
    endcase
  endfunction

  // Number of table slots, counting up from slot 0, that hold a written key.
  function automatic int filled_prefix();
    int p;
    p = 0;
    while (p < NUM_KEYS && sb.filled[p]) p++;
    return p;
  endfunction

  // Random item. A key count is only set where every slot it covers, and slot 0,
  // has been written; otherwise the count is cut back or the item becomes a write.
  task automatic random_item();
    int          sel;
    int          need;
    int          pre;
    logic [2:0]  act;
    logic [5:0]  idx;
    logic [6:0]  cnt;
    sel = $urandom_range(0, 99);
    idx = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    cnt = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 8)) : 7'($urandom);
    if (sel < 50)      act = klp_pkg::ACT_TICK;
    else if (sel < 57) act = klp_pkg::ACT_TOGGLE;
    else if (sel < 64) act = klp_pkg::ACT_SAVE;
    else if (sel < 72) act = klp_pkg::ACT_JOG;
    else if (sel < 86) act = klp_pkg::ACT_WRITE;
    else if (sel < 96) act = klp_pkg::ACT_COUNT;
    else               act = 3'($urandom_range(6, 7));
    if (act == klp_pkg::ACT_COUNT) begin
      need = (cnt > NUM_KEYS) ? NUM_KEYS : cnt;
      if (need == 0) need = 1;
      pre = filled_prefix();
      if (pre < need) begin
        if (pre == 0) begin
          act = klp_pkg::ACT_WRITE;
          idx = '0;
        end else begin
          cnt = 7'(pre);
        end
      end
    end
    send_item(act, 2'($urandom), 2'($urandom), 2'($urandom), idx,
              pick_coord(), pick_coord(), pick_coord(), cnt);
  endtask

  task automatic random_phase(int count);
    repeat (count) random_item();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed opening: ticks and a toggle on an empty player, table extremes,
    // jogs at both extremes including the most negative pattern, saves, unused actions.
    send_item(klp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_WRITE, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(klp_pkg::ACT_WRITE, 0, 0, 0, 1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
    send_item(klp_pkg::ACT_WRITE, 0, 0, 0, 63, 32'sh00010000, -32'sh00010000, 0, 0);
    send_item(klp_pkg::ACT_COUNT, 0, 0, 0, 0, 0, 0, 0, 7'd1);
    send_item(klp_pkg::ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_JOG, 2'sb01, 2'sb01, 2'sb01, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_JOG, 2'sb10, 2'sb10, 2'sb10, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_JOG, 2'sb11, 2'sb00, 2'sb11, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_SAVE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_COUNT, 0, 0, 0, 0, 0, 0, 0, 7'd2);
    send_item(klp_pkg::ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(klp_pkg::ACT_SAVE, 0, 0, 0, 0, 0, 0, 0, 0);

    // Short segments let playback run through to the end; the long setting and a step count
    // of zero check the division at its extremes.
    write_steps(16'd1);
    random_phase(400);
    no_gaps = 1;
    write_steps(16'd2);
    random_phase(300);
    no_gaps = 0;
    write_steps(16'd0);
    random_phase(300);
    write_steps(16'd3);
    random_phase(400);
    write_steps(16'd65535);
    random_phase(200);
    no_gaps = 1;
    write_steps(16'd4);
    random_phase(200);
    no_gaps = 0;
    write_steps(16'd1);
    random_phase(200);

    in_valid <= 0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results over seven step settings; %0d playbacks finished,",
             sb.matched, sb.finishes);
    $display("%0d saves refused on a full table, %0d mismatching fields.",
             sb.refusals, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/klp_pkg.sv
rtl/klp_ram.sv
rtl/keyframe_linear_player_unit.sv
tb/tb_keyframe_linear_player_unit.sv
